// File: design/crc8f_pkg.sv
package crc8f_pkg;

  // Reflected CRC-8 polynomial, LSB-first
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Configuration register indexes
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_ACK_MARKER   = 2'd1;
  localparam logic [1:0] REG_OWN_ADDRESS  = 2'd2;

  // Frame kinds
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  // One classified transaction handed from the front to the emitter
  typedef struct packed {
    logic       first;     // opens a frame: send four header bytes
    logic [7:0] marker;
    logic [7:0] dest;
    logic [7:0] src;
    logic [7:0] plen;
    logic       has_data;
    logic [7:0] data;
    logic       eof;       // closes the frame: send CRC byte
    logic [7:0] crc;       // CRC value to send when eof is set
  } cmd_t;

  // Byte-wide CRC update, bit 0 of the byte first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       mix;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ b[k];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// File: design/crc8f_front.sv
module crc8f_front
  import crc8f_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // input transaction
  input  logic       acc,
  input  logic       frame_kind,
  input  logic [7:0] dest_addr,
  input  logic [7:0] payload_length,
  input  logic       has_data,
  input  logic [7:0] data_byte,
  input  logic       end_of_frame,
  // classified command toward the queue
  output logic       push,
  output cmd_t       cmd
);

  logic [7:0] start_marker_r;
  logic [7:0] ack_marker_r;
  logic [7:0] own_address_r;
  logic       in_frame_r, in_frame_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] crc_hdr;
  logic [7:0] crc_base;
  logic [7:0] crc_new;
  logic       first;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= '0;
      ack_marker_r   <= '0;
      own_address_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_MARKER: start_marker_r <= cfg_wdata;
        REG_ACK_MARKER:   ack_marker_r   <= cfg_wdata;
        REG_OWN_ADDRESS:  own_address_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify and advance the running CRC
  always_comb begin
    first    = !in_frame_r;
    crc_hdr  = crc8_update(crc8_update(8'h00, dest_addr), own_address_r);
    crc_base = first ? crc_hdr : crc_r;
    crc_new  = has_data ? crc8_update(crc_base, data_byte) : crc_base;

    in_frame_nxt = in_frame_r;
    crc_nxt      = crc_r;
    if (acc) begin
      in_frame_nxt = !end_of_frame;
      crc_nxt      = end_of_frame ? 8'h00 : crc_new;
    end

    cmd.first    = first;
    cmd.marker   = (frame_kind == KIND_ACK) ? ack_marker_r : start_marker_r;
    cmd.dest     = dest_addr;
    cmd.src      = own_address_r;
    cmd.plen     = payload_length;
    cmd.has_data = has_data;
    cmd.data     = data_byte;
    cmd.eof      = end_of_frame;
    cmd.crc      = crc_new;

    // idle transactions inside a frame produce no bytes
    push = acc && (first || has_data || end_of_frame);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      crc_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      crc_r      <= crc_nxt;
    end
  end

endmodule

// File: design/crc8f_fifo.sv
module crc8f_fifo
  import crc8f_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rd_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_cmd  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: design/crc8f_emit.sv
module crc8f_emit
  import crc8f_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // queue side
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  // result transaction
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_done
);

  localparam logic [2:0] ST_MARK = 3'd0;
  localparam logic [2:0] ST_DEST = 3'd1;
  localparam logic [2:0] ST_SRC  = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;
  localparam logic [2:0] ST_CRC  = 3'd5;

  cmd_t       cur_r, cur_nxt;
  logic       vld_r, vld_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] adv_step;
  logic       last;
  logic [2:0] start_step;
  logic       out_acc;

  // Step that follows the current one; last flags end of this command
  always_comb begin
    adv_step = step_r;
    last     = 1'b0;
    unique case (step_r)
      ST_MARK: adv_step = ST_DEST;
      ST_DEST: adv_step = ST_SRC;
      ST_SRC:  adv_step = ST_LEN;
      ST_LEN: begin
        if (cur_r.has_data) begin
          adv_step = ST_DATA;
        end else if (cur_r.eof) begin
          adv_step = ST_CRC;
        end else begin
          last = 1'b1;
        end
      end
      ST_DATA: begin
        if (cur_r.eof) begin
          adv_step = ST_CRC;
        end else begin
          last = 1'b1;
        end
      end
      ST_CRC:  last = 1'b1;
      default: last = 1'b1;
    endcase
  end

  // First step of a freshly loaded command
  always_comb begin
    if (q_cmd.first) begin
      start_step = ST_MARK;
    end else if (q_cmd.has_data) begin
      start_step = ST_DATA;
    end else begin
      start_step = ST_CRC;
    end
  end

  // Load, advance or drain
  always_comb begin
    out_acc  = vld_r && out_ready;
    q_pop    = (!vld_r || (out_acc && last)) && !q_empty;
    cur_nxt  = cur_r;
    vld_nxt  = vld_r;
    step_nxt = step_r;
    if (q_pop) begin
      cur_nxt  = q_cmd;
      vld_nxt  = 1'b1;
      step_nxt = start_step;
    end else if (out_acc && last) begin
      vld_nxt = 1'b0;
    end else if (out_acc) begin
      step_nxt = adv_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      step_r <= ST_MARK;
    end else begin
      vld_r  <= vld_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Byte select for the current step
  always_comb begin
    out_frame_done = 1'b0;
    unique case (step_r)
      ST_MARK: out_tx_byte = cur_r.marker;
      ST_DEST: out_tx_byte = cur_r.dest;
      ST_SRC:  out_tx_byte = cur_r.src;
      ST_LEN:  out_tx_byte = cur_r.plen;
      ST_DATA: out_tx_byte = cur_r.data;
      ST_CRC: begin
        out_tx_byte    = cur_r.crc;
        out_frame_done = 1'b1;
      end
      default: out_tx_byte = cur_r.data;
    endcase
  end

  assign out_valid = vld_r;

endmodule

// File: design/crc8_message_framer.sv
// Channel | Direction | Ports
// --------+-----------+---------------------------------------------------------------
// in      | input     | in_valid/in_ready; frame_kind, dest_addr, payload_length,
//         |           | has_data, data_byte, end_of_frame
// out     | output    | out_valid/out_ready; tx_byte, frame_done
// cfg     | input     | cfg_wr_en, cfg_index, cfg_wdata (0 start, 1 ack, 2 own address)
//
// One byte per cycle while out_ready is high and bytes are pending; a transaction
// emits 0 to 6 bytes: 4 header bytes on the first of a frame, 1 per payload byte,
// 1 for the CRC. The front classifies and updates the CRC and accepts while the
// queue (QUEUE_DEPTH entries) has room; the emitter stalls on out_ready alone.
// Synchronous active-low reset clears framing state, queue and output valid.
module crc8_message_framer
  import crc8f_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_frame_kind,
  input  logic [7:0] in_dest_addr,
  input  logic [7:0] in_payload_length,
  input  logic       in_has_data,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_frame,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_done
);

  logic in_acc;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_cmd;

  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  crc8f_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .acc            (in_acc),
    .frame_kind     (in_frame_kind),
    .dest_addr      (in_dest_addr),
    .payload_length (in_payload_length),
    .has_data       (in_has_data),
    .data_byte      (in_data_byte),
    .end_of_frame   (in_end_of_frame),
    .push           (push),
    .cmd            (push_cmd)
  );

  crc8f_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (push_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_cmd)
  );

  crc8f_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_byte    (out_tx_byte),
    .out_frame_done (out_frame_done)
  );

endmodule

// File: design/crc8f_checker.sv
module crc8f_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_has_data,
  input logic       in_end_of_frame,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_frame_done
);

  logic       in_acc;
  logic       out_acc;
  logic [7:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Frames closed at the input but not yet closed at the output
  always_comb begin
    pend_nxt = pend_r;
    if ((in_acc && in_end_of_frame) && !(out_acc && out_frame_done)) begin
      pend_nxt = pend_r + 8'd1;
    end else if (!(in_acc && in_end_of_frame) && (out_acc && out_frame_done)) begin
      pend_nxt = pend_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // No output right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) && $stable(out_frame_done))
    else $error("output changed while stalled");

  // A CRC byte only closes a frame whose last transaction was taken
  a_done_has_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_frame_done |-> pend_r != 8'd0)
    else $error("frame_done without a closed frame");

  // An accepted data or end-of-frame transaction reaches out_valid via the queue
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_has_data || in_end_of_frame) |=> ##1 out_valid)
    else $error("accepted bytes not presented");

endmodule

bind crc8_message_framer crc8f_checker u_crc8f_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_has_data     (in_has_data),
  .in_end_of_frame (in_end_of_frame),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_tx_byte     (out_tx_byte),
  .out_frame_done  (out_frame_done)
);

// File: dv/crc8_message_framer_test.sv
module crc8_message_framer_test;
  import crc8f_pkg::*;

  // index with no register behind it; writes to it must be dropped
  localparam logic [1:0] REG_NONE = 2'd3;

  localparam int RANDOM_BLOCKS = 4;
  localparam int ITEMS_PER_BLOCK = 110;
  localparam int PHASE_B_ROW = 2;
  localparam int PHASE_C_ROW = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int LONG_HOLD_AFTER = 300;
  localparam int CYCLE_LIMIT = 200000;

  // one input transaction, with an optional hand-typed expectation
  typedef struct packed {
    logic        frame_kind;
    logic [7:0]  dest_addr;
    logic [7:0]  payload_length;
    logic        has_data;
    logic [7:0]  data_byte;
    logic        end_of_frame;
    logic        typed;
    logic [2:0]  n_typed;
    logic [47:0] typed_bytes;   // emission order, first byte in the top lane
  } frame_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_done;
  } tx_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic       in_frame_kind;
  logic [7:0] in_dest_addr;
  logic [7:0] in_payload_length;
  logic       in_has_data;
  logic [7:0] in_data_byte;
  logic       in_end_of_frame;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_tx_byte;
  logic       out_frame_done;

  // predictor copy of the block's registers and framing state
  logic [7:0] cur_start = 8'h00;
  logic [7:0] cur_ack = 8'h00;
  logic [7:0] cur_own = 8'h00;
  logic       pr_in_frame = 1'b0;
  logic [7:0] pr_crc = 8'h00;

  frame_item_t offered_items[$];
  tx_result_t  pending_bytes[$];
  frame_item_t directed_rows[$];

  int  fail_count = 0;
  int  n_items = 0;
  int  results_taken = 0;
  int  cycle_count = 0;
  bit  no_gaps = 1'b0;
  bit  held_off = 1'b0;

  crc8_message_framer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_kind     (in_frame_kind),
    .in_dest_addr      (in_dest_addr),
    .in_payload_length (in_payload_length),
    .in_has_data       (in_has_data),
    .in_data_byte      (in_data_byte),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_byte       (out_tx_byte),
    .out_frame_done    (out_frame_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reflected CRC-8, poly 0x8C, one data bit per step, LSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = (c[0] ^ b[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic frame_item_t mk_row(input logic kind, input logic [7:0] dest,
                                         input logic [7:0] plen, input logic has,
                                         input logic [7:0] data, input logic eof,
                                         input int n_known, input logic [47:0] known);
    frame_item_t r;
    r.frame_kind     = kind;
    r.dest_addr      = dest;
    r.payload_length = plen;
    r.has_data       = has;
    r.data_byte      = data;
    r.end_of_frame   = eof;
    r.typed          = (n_known >= 0);
    r.n_typed        = (n_known >= 0) ? n_known[2:0] : 3'd0;
    r.typed_bytes    = known;
    return r;
  endfunction

  // expected frame bytes for one accepted transaction; advances predictor state
  task automatic frame_bytes_predict(input frame_item_t it);
    tx_result_t calc[$];
    if (!pr_in_frame) begin
      calc.push_back({(it.frame_kind == KIND_ACK) ? cur_ack : cur_start, 1'b0});
      calc.push_back({it.dest_addr, 1'b0});
      calc.push_back({cur_own, 1'b0});
      calc.push_back({it.payload_length, 1'b0});
      pr_crc = crc8_next(crc8_next(8'h00, it.dest_addr), cur_own);
      pr_in_frame = 1'b1;
    end
    if (it.has_data) begin
      calc.push_back({it.data_byte, 1'b0});
      pr_crc = crc8_next(pr_crc, it.data_byte);
    end
    if (it.end_of_frame) begin
      calc.push_back({pr_crc, 1'b1});
      pr_in_frame = 1'b0;
      pr_crc = 8'h00;
    end
    if (it.typed) begin
      // hand-typed rows: queue the bytes as written in the table
      for (int i = 0; i < it.n_typed; i++) begin
        pending_bytes.push_back({it.typed_bytes[47 - 8 * i -: 8],
                                 it.end_of_frame && (i == it.n_typed - 1)});
      end
    end else begin
      foreach (calc[i]) pending_bytes.push_back(calc[i]);
    end
  endtask

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    frame_item_t it;
    tx_result_t  want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (offered_items.size() == 0) begin
          fail_count++;
          $display("%0t input transaction with nothing offered", $time);
        end else begin
          it = offered_items.pop_front();
          frame_bytes_predict(it);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          fail_count++;
          $display("%0t unexpected byte: expected none, actual tx %02h done %0b",
                   $time, out_tx_byte, out_frame_done);
        end else begin
          want = pending_bytes.pop_front();
          if (out_tx_byte !== want.tx_byte) begin
            fail_count++;
            $display("%0t tx_byte mismatch: expected %02h, actual %02h",
                     $time, want.tx_byte, out_tx_byte);
          end
          if (out_frame_done !== want.frame_done) begin
            fail_count++;
            $display("%0t frame_done mismatch: expected %0b, actual %0b",
                     $time, want.frame_done, out_frame_done);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // offer one transaction; called and returns at a falling edge
  task automatic send_item(input frame_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    offered_items.push_back(it);
    in_frame_kind     <= it.frame_kind;
    in_dest_addr      <= it.dest_addr;
    in_payload_length <= it.payload_length;
    in_has_data       <= it.has_data;
    in_data_byte      <= it.data_byte;
    in_end_of_frame   <= it.end_of_frame;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and wait until the block has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0 || offered_items.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all three registers, then the unused index
  task automatic set_regs(input logic [7:0] start_m, input logic [7:0] ack_m,
                          input logic [7:0] own);
    logic [7:0] vals [4];
    vals[0] = start_m;
    vals[1] = ack_m;
    vals[2] = own;
    vals[3] = 8'($urandom_range(0, 255));
    for (int r = 0; r < 4; r++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= r[1:0];
      cfg_wdata <= vals[r];
      @(negedge clk);
      case (r[1:0])
        REG_START_MARKER: cur_start = vals[r];
        REG_ACK_MARKER:   cur_ack = vals[r];
        REG_OWN_ADDRESS:  cur_own = vals[r];
        REG_NONE:         ;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  // one well-formed frame with random content, idle items and length mismatches
  task automatic random_frame();
    int          n_pay;
    int          sent;
    bit          sep_close;
    bit          first;
    bit          idle;
    logic [7:0]  plen;
    frame_item_t it;
    n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    plen = 8'(n_pay);
    if ($urandom_range(0, 4) == 0) plen = 8'($urandom_range(0, 255));
    sep_close = $urandom_range(0, 1);
    sent = 0;
    first = 1'b1;
    do begin
      // header fields are random on every item; only the first one counts
      it = mk_row(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)),
                  1'b0, -1, '0);
      if (first) it.payload_length = plen;
      idle = !first && ($urandom_range(0, 7) == 0);
      if (!idle) begin
        if (sent < n_pay) begin
          it.has_data = 1'b1;
          sent++;
          it.end_of_frame = (sent == n_pay) && !sep_close;
        end else if (!(first && sep_close)) begin
          it.end_of_frame = 1'b1;
        end
      end
      n_items++;
      send_item(it);
      first = 1'b0;
    end while (!it.end_of_frame);
  endtask

  // result side: random ready gaps plus one long hold-off
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!held_off && results_taken >= LONG_HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = REG_START_MARKER;
    cfg_wdata         = 8'h00;
    in_valid          = 1'b0;
    in_frame_kind     = KIND_NORMAL;
    in_dest_addr      = 8'h00;
    in_payload_length = 8'h00;
    in_has_data       = 1'b0;
    in_data_byte      = 8'h00;
    in_end_of_frame   = 1'b0;

    // directed rows: kind, dest, plen, has_data, data, eof, typed count (-1: predict), bytes
    // registers at reset: all-zero empty frame has header and CRC of zero
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
                                   5, 48'h00_00_00_00_00_00));
    directed_rows.push_back(mk_row(KIND_ACK, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b1, -1, '0));
    // markers A5/5A, own address 3C
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h12, 8'h03, 1'b0, 8'h00, 1'b0,
                                   4, 48'hA5_12_3C_03_00_00));
    // idle item inside a frame, header fields ignored
    directed_rows.push_back(mk_row(KIND_ACK, 8'hFF, 8'hFF, 1'b0, 8'hEE, 1'b0, 0, '0));
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0,
                                   1, 48'h00_00_00_00_00_00));
    directed_rows.push_back(mk_row(KIND_ACK, 8'h77, 8'h55, 1'b1, 8'hFF, 1'b0,
                                   1, 48'hFF_00_00_00_00_00));
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h00, 8'h00, 1'b1, 8'h80, 1'b1, -1, '0));
    directed_rows.push_back(mk_row(KIND_ACK, 8'h01, 8'h02, 1'b1, 8'h55, 1'b0,
                                   5, 48'h5A_01_3C_02_55_00));
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h00, 8'h00, 1'b1, 8'hAA, 1'b1, -1, '0));
    // one-item frame: header, data and CRC from a single transaction
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'hFE, 8'h01, 1'b1, 8'h01, 1'b1, -1, '0));
    // length byte says 9, only one payload byte follows
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h40, 8'h09, 1'b1, 8'h7E, 1'b0,
                                   5, 48'hA5_40_3C_09_7E_00));
    directed_rows.push_back(mk_row(KIND_ACK, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b1, -1, '0));
    directed_rows.push_back(mk_row(KIND_ACK, 8'h00, 8'h80, 1'b0, 8'h00, 1'b1, -1, '0));
    // markers FF/00, own address FF
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0,
                                   5, 48'hFF_00_FF_00_FF_00));
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, -1, '0));
    directed_rows.push_back(mk_row(KIND_ACK, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b1, -1, '0));
    directed_rows.push_back(mk_row(KIND_ACK, 8'h5A, 8'h10, 1'b0, 8'h00, 1'b0,
                                   4, 48'h00_5A_FF_10_00_00));
    directed_rows.push_back(mk_row(KIND_NORMAL, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, -1, '0));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (i == PHASE_B_ROW) begin
        settle();
        set_regs(8'hA5, 8'h5A, 8'h3C);
      end
      if (i == PHASE_C_ROW) begin
        settle();
        set_regs(8'hFF, 8'h00, 8'hFF);
      end
      n_items++;
      send_item(directed_rows[i]);
    end

    // random frames in blocks, new register settings between blocks
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      settle();
      if (blk == 1) begin
        set_regs(8'h00, 8'hFF, 8'h00);
      end else begin
        set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      end
      no_gaps = (blk == 2);
      while (n_items < directed_rows.size() + (blk + 1) * ITEMS_PER_BLOCK) random_frame();
    end
    no_gaps = 1'b0;

    // drain
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0 || offered_items.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/crc8f_pkg.sv
design/crc8f_front.sv
design/crc8f_fifo.sv
design/crc8f_emit.sv
design/crc8_message_framer.sv
design/crc8f_checker.sv
dv/crc8_message_framer_test.sv
